// ----- rtl/etok_pkg.sv -----
// ----------------------------------------------------------------------------
// Expression tokenizer package
// Shared constants, token codes and queue entry types of the tokenizer.
// ----------------------------------------------------------------------------
package etok_pkg;

  localparam int unsigned MAX_EXPR_LEN_DEF = 4096;
  localparam int unsigned POS_OUT_W        = 12;
  localparam int unsigned QUEUE_DEPTH      = 4;

  localparam logic [63:0] OPERATOR_RESET  = 64'h0000_005E_2F2A_2D2B;
  localparam logic [31:0] SEPARATOR_RESET = 32'h0D0A_0920;

  typedef enum logic [2:0] {
    KIND_NUMBER  = 3'd0,
    KIND_NAME    = 3'd1,
    KIND_OPEN    = 3'd2,
    KIND_CLOSE   = 3'd3,
    KIND_OPER    = 3'd4,
    KIND_END_OK  = 3'd5,
    KIND_END_ERR = 3'd6
  } token_kind_e;

  typedef enum logic [0:0] {
    CFG_OPERATOR  = 1'b0,
    CFG_SEPARATOR = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    token_kind_e          kind;
    logic [7:0]           chr;
    logic [POS_OUT_W-1:0] start_pos;
    logic [POS_OUT_W-1:0] end_pos;
    logic                 last;
  } token_t;

  // Each queue entry holds the one or two tokens yielded by one accepted character.
  typedef struct packed {
    logic   two;
    token_t first;
    token_t second;
  } entry_t;

endpackage

// ----- rtl/etok_if.sv -----
// ----------------------------------------------------------------------------
// Expression tokenizer channels
// Valid/ready interfaces for characters, tokens and configuration writes.
// ----------------------------------------------------------------------------
interface etok_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] character;

  modport source (output valid, output character, input ready);
  modport sink (input valid, input character, output ready);
endinterface

interface etok_token_if;
  logic        valid;
  logic        ready;
  logic [2:0]  token_kind;
  logic [7:0]  token_char;
  logic [11:0] start_pos;
  logic [11:0] end_pos;
  logic        last;

  modport source (output valid, output token_kind, output token_char,
                  output start_pos, output end_pos, output last, input ready);
  modport sink (input valid, input token_kind, input token_char,
                input start_pos, input end_pos, input last, output ready);
endinterface

interface etok_cfg_if;
  logic        valid;
  logic        ready;
  logic [0:0]  index;
  logic [63:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ----- rtl/etok_front.sv -----
// ----------------------------------------------------------------------------
// Expression tokenizer front end
// Classifies each character, steps the lexer automaton and queues tokens.
// ----------------------------------------------------------------------------
module etok_front
  import etok_pkg::*;
#(
  parameter int unsigned MaxExprLen = MAX_EXPR_LEN_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  etok_char_if.sink     char_i,
  etok_cfg_if.sink      cfg_i,
  input  logic          full_i,
  output logic          push_o,
  output entry_t        entry_o
);

  localparam int unsigned PosW = $clog2(MaxExprLen + 1);
  localparam logic [PosW-1:0] PosMax = PosW'(MaxExprLen);

  localparam logic [2:0] ST_START = 3'd0;
  localparam logic [2:0] ST_INT   = 3'd1;
  localparam logic [2:0] ST_FLT   = 3'd2;
  localparam logic [2:0] ST_NAME  = 3'd3;
  localparam logic [2:0] ST_OPEN  = 3'd4;
  localparam logic [2:0] ST_CLOSE = 3'd5;
  localparam logic [2:0] ST_OPER  = 3'd6;

  logic [63:0]     oper_q;
  logic [31:0]     sep_q;
  logic [2:0]      state_q, nx_state;
  logic [PosW-1:0] pos_q, tstart_q, lastnon_q;
  logic            disc_q;

  logic [7:0] c;
  logic       accept;
  logic       dig, let_c, dot, opn, cls, opr, is_sep;
  logic       nx_stop, nx_bad;
  logic       q_data, nx_data, ovf;
  logic       has_pend, has_chr;
  token_t     pend_tok, chr_tok, ovf_tok;

  function automatic logic is_data(input logic [2:0] st);
    return (st == ST_INT) || (st == ST_FLT) || (st == ST_NAME);
  endfunction

  assign c      = char_i.character;
  assign char_i.ready = !full_i;
  assign accept = char_i.valid && char_i.ready;
  assign cfg_i.ready = 1'b1;

  always_comb begin
    dig   = (c >= 8'h30) && (c <= 8'h39);
    let_c = ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
    dot   = (c == 8'h2E);
    opn   = (c == 8'h28);
    cls   = (c == 8'h29);
    opr   = 1'b0;
    for (int i = 0; i < 8; i++) begin
      if (oper_q[8*i +: 8] != 8'h00 && oper_q[8*i +: 8] == c) begin
        opr = 1'b1;
      end
    end
    // A zero byte never counts as a separator, so a match implies nonzero.
    is_sep = 1'b0;
    for (int i = 0; i < 4; i++) begin
      if (c != 8'h00 && sep_q[8*i +: 8] == c) begin
        is_sep = 1'b1;
      end
    end
  end

  always_comb begin
    nx_state = state_q;
    nx_stop  = 1'b0;
    nx_bad   = 1'b0;
    if (c == 8'h00) begin
      nx_stop = 1'b1;
    end else begin
      unique case (state_q) inside
        ST_START, ST_OPEN, ST_OPER: begin
          if (dig)        nx_state = ST_INT;
          else if (let_c) nx_state = ST_NAME;
          else if (opn)   nx_state = ST_OPEN;
          else if (opr)   nx_state = ST_OPER;
          else            nx_bad   = 1'b1;
        end
        ST_INT: begin
          if (dig)      nx_state = ST_INT;
          else if (dot) nx_state = ST_FLT;
          else if (opr) nx_state = ST_OPER;
          else if (cls) nx_state = ST_CLOSE;
          else          nx_bad   = 1'b1;
        end
        ST_FLT: begin
          if (dig)      nx_state = ST_FLT;
          else if (opr) nx_state = ST_OPER;
          else if (cls) nx_state = ST_CLOSE;
          else          nx_bad   = 1'b1;
        end
        ST_NAME: begin
          if (dig || let_c) nx_state = ST_NAME;
          else if (opn)     nx_state = ST_OPEN;
          else if (opr)     nx_state = ST_OPER;
          else if (cls)     nx_state = ST_CLOSE;
          else              nx_bad   = 1'b1;
        end
        ST_CLOSE: begin
          if (opr)      nx_state = ST_OPER;
          else if (cls) nx_state = ST_CLOSE;
          else          nx_bad   = 1'b1;
        end
        default: nx_bad = 1'b1;
      endcase
    end
  end

  always_comb begin
    ovf     = (pos_q >= PosMax);
    q_data  = is_data(state_q);
    nx_data = !nx_stop && !nx_bad && is_data(nx_state);
    // A pending number or name ends on any change except the integer-to-float step.
    has_pend = q_data && (nx_stop || nx_bad || nx_state != state_q) &&
               !(state_q == ST_INT && nx_data && nx_state == ST_FLT);
    has_chr  = nx_stop || nx_bad ||
               nx_state == ST_OPEN || nx_state == ST_CLOSE || nx_state == ST_OPER;

    pend_tok.kind      = (state_q == ST_NAME) ? KIND_NAME : KIND_NUMBER;
    pend_tok.chr       = 8'h00;
    pend_tok.start_pos = POS_OUT_W'(tstart_q);
    pend_tok.end_pos   = POS_OUT_W'(lastnon_q);
    pend_tok.last      = !has_chr;

    if (nx_stop)                  chr_tok.kind = KIND_END_OK;
    else if (nx_bad)              chr_tok.kind = KIND_END_ERR;
    else if (nx_state == ST_OPEN) chr_tok.kind = KIND_OPEN;
    else if (nx_state == ST_CLOSE) chr_tok.kind = KIND_CLOSE;
    else                          chr_tok.kind = KIND_OPER;
    chr_tok.chr       = (nx_stop || nx_bad) ? 8'h00 : c;
    chr_tok.start_pos = POS_OUT_W'(pos_q);
    chr_tok.end_pos   = POS_OUT_W'(pos_q);
    chr_tok.last      = 1'b1;

    ovf_tok.kind      = KIND_END_ERR;
    ovf_tok.chr       = 8'h00;
    ovf_tok.start_pos = POS_OUT_W'(pos_q);
    ovf_tok.end_pos   = POS_OUT_W'(pos_q);
    ovf_tok.last      = 1'b1;

    if (ovf) begin
      entry_o.two   = 1'b0;
      entry_o.first = ovf_tok;
    end else begin
      entry_o.two   = has_pend && has_chr;
      entry_o.first = has_pend ? pend_tok : chr_tok;
    end
    entry_o.second = chr_tok;

    push_o = accept && !disc_q && (ovf || (!is_sep && (has_pend || has_chr)));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oper_q <= OPERATOR_RESET;
      sep_q  <= SEPARATOR_RESET;
    end else if (cfg_i.valid) begin
      case (cfg_idx_e'(cfg_i.index))
        CFG_OPERATOR:  oper_q <= cfg_i.data;
        CFG_SEPARATOR: sep_q  <= cfg_i.data[31:0];
        default:       oper_q <= oper_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_START;
      pos_q     <= '0;
      tstart_q  <= '0;
      lastnon_q <= '0;
      disc_q    <= 1'b0;
    end else if (accept) begin
      if (disc_q || ovf || (!is_sep && (nx_stop || nx_bad))) begin
        // Restart on a terminator, or enter discard mode on any error.
        if (c == 8'h00) begin
          state_q   <= ST_START;
          pos_q     <= '0;
          tstart_q  <= '0;
          lastnon_q <= '0;
          disc_q    <= 1'b0;
        end else if (!disc_q && ovf) begin
          disc_q <= 1'b1;
        end else if (!disc_q) begin
          state_q   <= ST_START;
          pos_q     <= '0;
          tstart_q  <= '0;
          lastnon_q <= '0;
          disc_q    <= 1'b1;
        end
      end else if (is_sep) begin
        pos_q <= pos_q + 1'b1;
      end else begin
        if (!q_data && nx_data) begin
          tstart_q <= pos_q;
        end
        state_q   <= nx_state;
        lastnon_q <= pos_q;
        pos_q     <= pos_q + 1'b1;
      end
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && disc_q |-> !push_o)
    else $error("token queued while discarding input");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= PosMax)
    else $error("position beyond its saturation value");

endmodule

// ----- rtl/etok_queue.sv -----
// ----------------------------------------------------------------------------
// Expression tokenizer queue
// Short FIFO of token entries between the front end and the output stage.
// ----------------------------------------------------------------------------
module etok_queue
  import etok_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  entry_t entry_i,
  input  logic   pop_i,
  output entry_t entry_o,
  output logic   empty_o,
  output logic   full_o
);

  localparam int unsigned PtrW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  entry_t          mem_q [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_push, do_pop;

  assign empty_o = (count_q == '0);
  assign full_o  = (count_q == CntW'(QUEUE_DEPTH));
  assign entry_o = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) wr_ptr_q <= PtrW'((CntW'(wr_ptr_q) + 1'b1) % CntW'(QUEUE_DEPTH));
      if (do_pop)  rd_ptr_q <= PtrW'((CntW'(rd_ptr_q) + 1'b1) % CntW'(QUEUE_DEPTH));
      if (do_push && !do_pop)      count_q <= count_q + 1'b1;
      else if (do_pop && !do_push) count_q <= count_q - 1'b1;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o))
    else $error("push into a full token queue");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(QUEUE_DEPTH))
    else $error("token queue count overflow");

endmodule

// ----- rtl/etok_back.sv -----
// ----------------------------------------------------------------------------
// Expression tokenizer output stage
// Takes queue entries and presents their tokens one transfer at a time.
// ----------------------------------------------------------------------------
module etok_back
  import etok_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  entry_t        entry_i,
  input  logic          empty_i,
  output logic          pop_o,
  etok_token_if.source  tok_o
);

  entry_t cur_q;
  logic   valid_q, phase_q;
  logic   xfer, final_tok, load;
  token_t sel;

  assign sel       = phase_q ? cur_q.second : cur_q.first;
  assign xfer      = valid_q && tok_o.ready;
  assign final_tok = !cur_q.two || phase_q;
  assign load      = !valid_q || (xfer && final_tok);
  assign pop_o     = load && !empty_i;

  assign tok_o.valid      = valid_q;
  assign tok_o.token_kind = sel.kind;
  assign tok_o.token_char = sel.chr;
  assign tok_o.start_pos  = sel.start_pos;
  assign tok_o.end_pos    = sel.end_pos;
  assign tok_o.last       = sel.last;

  always_ff @(posedge clk_i) begin
    if (load) begin
      cur_q <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      phase_q <= 1'b0;
    end else if (load) begin
      valid_q <= !empty_i;
      phase_q <= 1'b0;
    end else if (xfer) begin
      phase_q <= 1'b1;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q |-> valid_q && cur_q.two)
    else $error("second token selected for a single-token entry");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    xfer && cur_q.two && !phase_q |=> phase_q && valid_q)
    else $error("second token of an entry was skipped");

endmodule

// ----- rtl/expression_tokenizer.sv -----
// A character's tokens are written into the queue at the edge that accepts
// it, then registered into the output stage, which offers them in turn.
// One character per cycle while the queue is not full; a character yielding
// two tokens takes two output transfers, and a four-entry queue absorbs bursts.
// Reset clears the automaton, position, discard flag and queue at once and
// loads the default operator and separator sets; no clearing pass is needed.
// ----------------------------------------------------------------------------
// Expression tokenizer
// Lexes arithmetic expressions into number, name, bracket and operator tokens.
// ----------------------------------------------------------------------------
module expression_tokenizer
  import etok_pkg::*;
#(
  parameter int unsigned MaxExprLen = MAX_EXPR_LEN_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  etok_char_if.sink     char_i,
  etok_cfg_if.sink      cfg_i,
  etok_token_if.source  tok_o
);

  logic   push, pop, empty, full;
  entry_t push_entry, head_entry;

  etok_front #(
    .MaxExprLen(MaxExprLen)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .char_i  (char_i),
    .cfg_i   (cfg_i),
    .full_i  (full),
    .push_o  (push),
    .entry_o (push_entry)
  );

  etok_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .pop_i   (pop),
    .entry_o (head_entry),
    .empty_o (empty),
    .full_o  (full)
  );

  etok_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .entry_i (head_entry),
    .empty_i (empty),
    .pop_o   (pop),
    .tok_o   (tok_o)
  );

endmodule
